[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL that carries checks.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/pcc_pkg.sv]
// Shared types for the polygon convexity checker.
// No dependencies; used by pcc_cross and polygon_convexity_check.
package pcc_pkg;

   // Sign of one cross product; also the winding code on the result port.
   typedef enum logic [1:0] {
      SIGN_NONE = 2'd0,
      SIGN_NEG  = 2'd1,
      SIGN_POS  = 2'd2
   } sign_type;

   // Vertices taken so far in the current polygon, saturating at two.
   typedef enum logic [1:0] {
      SEEN_NONE = 2'd0,
      SEEN_ONE  = 2'd1,
      SEEN_TWO  = 2'd2
   } seen_type;

   // Running sign state across the products of one polygon.
   typedef struct packed {
      sign_type first_sign;
      logic     broken;
   } acc_type;

endpackage

[rtl/core/polygon_convexity_check.sv]
// Polygon convexity checker, top level: vertex state, operand stage, sign merge.
// Depends on pcc_pkg, pcc_cross and assert_macros.svh.
//
//   channel | direction | carries                        | handshake
//   req_    | in        | vert_x, vert_y, is_last        | req_valid / req_ready
//   rsp_    | out       | is_convex, winding             | rsp_valid / rsp_ready
//
// One vertex per cycle while req_ready is high. After the last vertex transfer,
// the result passes the operand, multiply, sign and result registers.
// Reset is synchronous; it clears vertex count, sign state and result valid.
// The pipeline halts only when a finished result waits on rsp_ready and the
// next polygon's last vertex has reached the sign merge stage.
`include "assert_macros.svh"

module polygon_convexity_check
   import pcc_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_vert_x,
   input  logic signed [COORD_BITS-1:0] req_vert_y,
   input  logic                         req_is_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_is_convex,
   output logic [1:0]                   rsp_winding
);

   localparam int EDGE_BITS = COORD_BITS + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [EDGE_BITS-1:0]  edge_type;

   // vertex state
   seen_type  seen_ff;
   coord_type first_vx_ff, first_vy_ff, prev_vx_ff, prev_vy_ff;
   edge_type  first_edge_dx_ff, first_edge_dy_ff, prev_edge_dx_ff, prev_edge_dy_ff;

   // operand stage
   edge_type  c1_ax_ff, c1_ay_ff, c1_bx_ff, c1_by_ff;
   edge_type  c2_ax_ff, c2_ay_ff, c2_bx_ff, c2_by_ff;
   edge_type  c3_ax_ff, c3_ay_ff, c3_bx_ff, c3_by_ff;

   logic      v1_ff, v2_ff, v3_ff;
   logic      last1_ff, last2_ff, last3_ff;

   sign_type  s1, s2, s3;
   acc_type   acc_ff, acc_in;

   logic      rsp_valid_ff, rsp_is_convex_ff;
   sign_type  rsp_winding_ff;

   logic      advance, accept, finish;
   edge_type  ex, ey, cx, cy, fex, fey;
   logic      use1, use23;

   function automatic acc_type take_sign(acc_type a, sign_type s);
      acc_type r;
      r = a;
      if (s != SIGN_NONE) begin
         if (a.first_sign == SIGN_NONE) begin
            r.first_sign = s;
         end else if (a.first_sign != s) begin
            r.broken = 1'b1;
         end
      end
      return r;
   endfunction

   // Stall only when the merge stage would need the occupied result register.
   assign advance = !(rsp_valid_ff && !rsp_ready && v3_ff && last3_ff);
   assign req_ready = advance;
   assign accept = req_valid && advance;
   assign finish = advance && v3_ff && last3_ff;

   assign ex = EDGE_BITS'(req_vert_x) - EDGE_BITS'(prev_vx_ff);
   assign ey = EDGE_BITS'(req_vert_y) - EDGE_BITS'(prev_vy_ff);
   assign cx = EDGE_BITS'(first_vx_ff) - EDGE_BITS'(req_vert_x);
   assign cy = EDGE_BITS'(first_vy_ff) - EDGE_BITS'(req_vert_y);

   // With only two vertices so far, this vertex's edge is also the first edge.
   assign fex = (seen_ff == SEEN_ONE) ? ex : first_edge_dx_ff;
   assign fey = (seen_ff == SEEN_ONE) ? ey : first_edge_dy_ff;

   assign use1  = (seen_ff == SEEN_TWO);
   assign use23 = req_is_last && (seen_ff != SEEN_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= SEEN_NONE;
      end else if (accept) begin
         if (req_is_last) begin
            seen_ff <= SEEN_NONE;
         end else if (seen_ff == SEEN_NONE) begin
            seen_ff <= SEEN_ONE;
         end else begin
            seen_ff <= SEEN_TWO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (seen_ff == SEEN_NONE) begin
            first_vx_ff <= req_vert_x;
            first_vy_ff <= req_vert_y;
         end else begin
            if (seen_ff == SEEN_ONE) begin
               first_edge_dx_ff <= ex;
               first_edge_dy_ff <= ey;
            end
            prev_edge_dx_ff <= ex;
            prev_edge_dy_ff <= ey;
         end
         prev_vx_ff <= req_vert_x;
         prev_vy_ff <= req_vert_y;
      end
   end

   // Unused products get zero operands, so they read as no sign.
   always_ff @(posedge clock) begin
      if (advance) begin
         c1_ax_ff <= use1 ? prev_edge_dx_ff : '0;
         c1_ay_ff <= use1 ? prev_edge_dy_ff : '0;
         c1_bx_ff <= use1 ? ex : '0;
         c1_by_ff <= use1 ? ey : '0;
         c2_ax_ff <= use23 ? ex : '0;
         c2_ay_ff <= use23 ? ey : '0;
         c2_bx_ff <= use23 ? cx : '0;
         c2_by_ff <= use23 ? cy : '0;
         c3_ax_ff <= use23 ? cx : '0;
         c3_ay_ff <= use23 ? cy : '0;
         c3_bx_ff <= use23 ? fex : '0;
         c3_by_ff <= use23 ? fey : '0;
         last1_ff <= req_is_last;
         last2_ff <= last1_ff;
         last3_ff <= last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   pcc_cross #(.EDGE_BITS(EDGE_BITS)) u_cross1 (
      .clock      (clock),
      .enable     (advance),
      .ax         (c1_ax_ff),
      .ay         (c1_ay_ff),
      .bx         (c1_bx_ff),
      .by         (c1_by_ff),
      .cross_sign (s1)
   );

   pcc_cross #(.EDGE_BITS(EDGE_BITS)) u_cross2 (
      .clock      (clock),
      .enable     (advance),
      .ax         (c2_ax_ff),
      .ay         (c2_ay_ff),
      .bx         (c2_bx_ff),
      .by         (c2_by_ff),
      .cross_sign (s2)
   );

   pcc_cross #(.EDGE_BITS(EDGE_BITS)) u_cross3 (
      .clock      (clock),
      .enable     (advance),
      .ax         (c3_ax_ff),
      .ay         (c3_ay_ff),
      .bx         (c3_bx_ff),
      .by         (c3_by_ff),
      .cross_sign (s3)
   );

   // Products are taken in cyclic order: inner, then the two closing ones.
   assign acc_in = take_sign(take_sign(take_sign(acc_ff, s1), s2), s3);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '{first_sign: SIGN_NONE, broken: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new verdict may load in the same cycle the old one transfers
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance && v3_ff) begin
            if (last3_ff) begin
               acc_ff <= '{first_sign: SIGN_NONE, broken: 1'b0};
            end else begin
               acc_ff <= acc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_is_convex_ff <= !acc_in.broken;
         rsp_winding_ff   <= acc_in.first_sign;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_convex = rsp_is_convex_ff;
   assign rsp_winding   = rsp_winding_ff;

   `ASSERT_IMPLIES(a_stall_cause, clock, reset, !req_ready, rsp_valid_ff && v3_ff && last3_ff)
   `ASSERT_NEXT(a_finish_loads, clock, reset, finish, rsp_valid_ff)
   `ASSERT_NEXT(a_finish_clears, clock, reset, finish, acc_ff == '0)
   `ASSERT_IMPLIES(a_flat_is_convex, clock, reset, rsp_valid && rsp_winding == SIGN_NONE, rsp_is_convex)

endmodule

[rtl/core/pcc_cross.sv]
// Two-stage cross product sign unit: registered multiplies, then subtract and sign.
// Depends on pcc_pkg.
module pcc_cross
   import pcc_pkg::*;
#(
   parameter int EDGE_BITS = 17
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [EDGE_BITS-1:0] ax,
   input  logic signed [EDGE_BITS-1:0] ay,
   input  logic signed [EDGE_BITS-1:0] bx,
   input  logic signed [EDGE_BITS-1:0] by,
   output sign_type                    cross_sign
);

   localparam int PROD_BITS = 2 * EDGE_BITS;
   localparam int DIFF_BITS = PROD_BITS + 1;

   logic signed [PROD_BITS-1:0] prod_xy_ff, prod_yx_ff;
   logic signed [PROD_BITS-1:0] prod_xy_in, prod_yx_in;
   logic signed [DIFF_BITS-1:0] diff;
   sign_type                    sign_ff, sign_in;

   assign prod_xy_in = PROD_BITS'(ax) * PROD_BITS'(by);
   assign prod_yx_in = PROD_BITS'(ay) * PROD_BITS'(bx);

   assign diff = DIFF_BITS'(prod_xy_ff) - DIFF_BITS'(prod_yx_ff);

   always_comb begin
      if (diff == '0) begin
         sign_in = SIGN_NONE;
      end else if (diff[DIFF_BITS-1]) begin
         sign_in = SIGN_NEG;
      end else begin
         sign_in = SIGN_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_xy_ff <= prod_xy_in;
         prod_yx_ff <= prod_yx_in;
         sign_ff    <= sign_in;
      end
   end

   assign cross_sign = sign_ff;

endmodule
